// ===== sv/fbmap_pkg.sv =====
// ----------------------------------------------------------------------------
// fbmap_pkg
// Shared types, codes and sizes of the file block map allocator.
// ----------------------------------------------------------------------------
package fbmap_pkg;

    localparam int NUM_FILES      = 64;
    localparam int FILE_W         = 6;
    localparam int NUM_BLOCKS     = 1024;
    localparam int BLK_W          = 10;
    localparam int BLOCK_BYTES    = 1024;
    localparam int BOFF_W         = 10;
    localparam int OFFSET_W       = 19;
    localparam int LB_W           = OFFSET_W - BOFF_W;
    localparam int DIRECT_COUNT   = 10;
    localparam int DI_W           = 4;
    localparam int DIR_DEPTH      = NUM_FILES * DIRECT_COUNT;
    localparam int DIR_AW         = 10;
    localparam int INDIRECT_COUNT = 256;
    localparam int IE_IDX_W       = 8;
    localparam int IE_DEPTH       = NUM_FILES * INDIRECT_COUNT;
    localparam int IE_AW          = FILE_W + IE_IDX_W;
    localparam int MAP_LIMIT      = DIRECT_COUNT + INDIRECT_COUNT;
    localparam int FREED_W        = 9;
    localparam int BM_ROW_W       = 16;
    localparam int BM_BIT_W       = 4;
    localparam int BM_ROWS        = NUM_BLOCKS / BM_ROW_W;
    localparam int BM_ROW_AW      = BLK_W - BM_BIT_W;

    localparam logic [1:0] REQ_CLEAR   = 2'd0;
    localparam logic [1:0] REQ_MAP     = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_OUT_RANGE = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [BLK_W-1:0] blk;
    } ptr_t;

    typedef enum logic {
        BM_OP_ALLOC,
        BM_OP_FREE
    } bm_op_t;

    typedef struct packed {
        logic             valid;
        bm_op_t           op;
        logic [BLK_W-1:0] blk;
    } bm_req_t;

    typedef struct packed {
        logic             ready;
        logic             done;
        logic             ok;
        logic [BLK_W-1:0] blk;
    } bm_rsp_t;

    typedef enum logic [2:0] {
        BM_INIT,
        BM_IDLE,
        BM_SCAN_RD,
        BM_SCAN_CHK,
        BM_FREE_RD,
        BM_FREE_WR
    } bm_state_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_MAP_DIR_RD,
        S_MAP_DIR_CHK,
        S_MAP_IP_RD,
        S_MAP_IP_CHK,
        S_MAP_IP_WAIT,
        S_MAP_WIPE,
        S_MAP_IE_RD,
        S_MAP_IE_CHK,
        S_MAP_DATA_WAIT,
        S_REL_DIR_RD,
        S_REL_DIR_CHK,
        S_REL_DIR_WAIT,
        S_REL_IP_RD,
        S_REL_IP_CHK,
        S_REL_IE_RD,
        S_REL_IE_CHK,
        S_REL_IE_WAIT,
        S_REL_IB_ISSUE,
        S_REL_IB_WAIT,
        S_RESULT
    } seq_state_t;

endpackage

// ===== sv/fbmap_bitmap.sv =====
// ----------------------------------------------------------------------------
// fbmap_bitmap
// Free-block bitmap: finds and takes the lowest free block, or frees one.
// ----------------------------------------------------------------------------
module fbmap_bitmap
    import fbmap_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  bm_req_t req,
    output bm_rsp_t rsp
);

    logic [BM_ROW_W-1:0] mem [BM_ROWS];
    logic [BM_ROW_W-1:0] rd_reg;

    bm_state_t state_reg, state_next;
    logic [BM_ROW_AW-1:0] row_reg, row_next;
    logic [BM_BIT_W-1:0]  bit_reg, bit_next;

    logic                 we;
    logic [BM_ROW_W-1:0]  wd;
    logic [BM_BIT_W-1:0]  zero_idx;
    logic                 row_full;

    // Lowest clear bit of the row just read.
    always_comb
    begin
        zero_idx = '0;
        for (int i = BM_ROW_W - 1; i >= 0; i--)
        begin
            if (!rd_reg[i])
            begin
                zero_idx = BM_BIT_W'(i);
            end
        end
    end

    assign row_full = &rd_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BM_INIT:
            begin
                if (row_reg == BM_ROW_AW'(BM_ROWS - 1))
                begin
                    state_next = BM_IDLE;
                end
            end
            BM_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (req.op == BM_OP_ALLOC) ? BM_SCAN_RD : BM_FREE_RD;
                end
            end
            BM_SCAN_RD:  state_next = BM_SCAN_CHK;
            BM_SCAN_CHK:
            begin
                if (!row_full || row_reg == BM_ROW_AW'(BM_ROWS - 1))
                begin
                    state_next = BM_IDLE;
                end
                else
                begin
                    state_next = BM_SCAN_RD;
                end
            end
            BM_FREE_RD:  state_next = BM_FREE_WR;
            BM_FREE_WR:  state_next = BM_IDLE;
            default:     state_next = BM_IDLE;
        endcase
    end

    always_comb
    begin
        we        = 1'b0;
        wd        = '0;
        rsp.ready = (state_reg == BM_IDLE);
        rsp.done  = 1'b0;
        rsp.ok    = 1'b0;
        rsp.blk   = {row_reg, zero_idx};
        case (state_reg)
            BM_INIT:
            begin
                we = 1'b1;
            end
            BM_SCAN_CHK:
            begin
                if (!row_full)
                begin
                    we       = 1'b1;
                    wd       = rd_reg | (BM_ROW_W'(1) << zero_idx);
                    rsp.done = 1'b1;
                    rsp.ok   = 1'b1;
                end
                else if (row_reg == BM_ROW_AW'(BM_ROWS - 1))
                begin
                    rsp.done = 1'b1;
                end
            end
            BM_FREE_WR:
            begin
                we       = 1'b1;
                wd       = rd_reg & ~(BM_ROW_W'(1) << bit_reg);
                rsp.done = 1'b1;
                rsp.ok   = 1'b1;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        row_next = row_reg;
        bit_next = bit_reg;
        case (state_reg)
            BM_INIT:     row_next = row_reg + 1'b1;
            BM_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.op == BM_OP_ALLOC)
                    begin
                        row_next = '0;
                    end
                    else
                    begin
                        row_next = req.blk[BLK_W-1:BM_BIT_W];
                        bit_next = req.blk[BM_BIT_W-1:0];
                    end
                end
            end
            BM_SCAN_CHK: row_next = row_reg + 1'b1;
            default:     row_next = row_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BM_INIT;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[row_reg] <= wd;
        end
        rd_reg <= mem[row_reg];
    end

endmodule

// ===== sv/file_block_map_allocator_core.sv =====
// ----------------------------------------------------------------------------
// file_block_map_allocator_core
// Per-file direct and indirect block maps over a shared free-block bitmap.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel, one word each, and every request
// gives exactly one result word on the m_axis channel. A clear request
// empties the direct pointers and the indirect pointer of its file. A map
// request reads the direct pointer, or the indirect pointer and then the
// indirect entry, and has the bitmap search for each block it allocates,
// one 16-block row after another through all 64 rows at most; allocating an
// indirect block also wipes its 256-entry table. A release request frees the
// direct blocks up to the first empty pointer, then, if there is one, the
// indirect entries likewise and the indirect block itself. The single-port
// pointer memories and the one bitmap unit set the pace of all this.
// After reset the block sweeps its direct and indirect pointer memories, and
// the bitmap, with s_axis_tready low. A result sits in the output
// register until taken; the block may accept the next request meanwhile,
// and holds its finished result back only while the register is still full.
// ----------------------------------------------------------------------------
module file_block_map_allocator_core
    import fbmap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // file_index [5:0], byte_offset [24:6], zero [31:25]
    input  logic [31:0] s_axis_tdata,
    // req_type [1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // data_block [9:0], offset_in_block [19:10], blocks_freed [28:20], zero [31:29]
    output logic [31:0] m_axis_tdata,
    // status [1:0]
    output logic [1:0]  m_axis_tuser
);

    // Pointer memories: direct pointers, indirect pointers, indirect entries.
    ptr_t dir_mem [DIR_DEPTH];
    ptr_t ip_mem  [NUM_FILES];
    ptr_t ie_mem  [IE_DEPTH];
    ptr_t dir_rd_reg, ip_rd_reg, ie_rd_reg;

    logic              dir_we, ip_we, ie_we;
    logic [DIR_AW-1:0] dir_wa, dir_ra;
    logic [FILE_W-1:0] ip_wa;
    logic [IE_AW-1:0]  ie_wa, ie_ra;
    ptr_t              dir_wd, ip_wd, ie_wd;

    bm_req_t bm_req;
    bm_rsp_t bm_rsp;

    seq_state_t state_reg, state_next;

    logic [DIR_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [FILE_W-1:0]   file_reg, file_next;
    logic [BOFF_W-1:0]   boff_reg, boff_next;
    logic [DI_W-1:0]     di_reg, di_next;
    logic [IE_IDX_W-1:0] k_reg, k_next;
    logic [IE_IDX_W-1:0] tgt_reg, tgt_next;
    logic                tgt_ie_reg, tgt_ie_next;
    logic [BLK_W-1:0]    ipblk_reg, ipblk_next;
    logic [1:0]          status_reg, status_next;
    logic [BLK_W-1:0]    bnum_reg, bnum_next;
    logic [BOFF_W-1:0]   rboff_reg, rboff_next;
    logic [FREED_W-1:0]  freed_reg, freed_next;

    logic                m_valid_reg, m_valid_next;
    logic [1:0]          m_status_reg, m_status_next;
    logic [BLK_W-1:0]    m_bnum_reg, m_bnum_next;
    logic [BOFF_W-1:0]   m_boff_reg, m_boff_next;
    logic [FREED_W-1:0]  m_freed_reg, m_freed_next;

    logic                accept;
    logic [1:0]          in_req;
    logic [FILE_W-1:0]   in_file;
    logic [BOFF_W-1:0]   in_boff;
    logic [LB_W-1:0]     in_lb;
    logic [DIR_AW-1:0]   dir_base;
    logic                out_free;

    assign in_req  = s_axis_tuser;
    assign in_file = s_axis_tdata[FILE_W-1:0];
    assign in_boff = s_axis_tdata[FILE_W +: BOFF_W];
    assign in_lb   = s_axis_tdata[FILE_W + BOFF_W +: LB_W];

    assign s_axis_tready = (state_reg == S_IDLE) && bm_rsp.ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // The direct pointers of file f sit at f * 10 onwards.
    assign dir_base = {1'b0, file_reg, 3'b000}
                    + {{(DIR_AW-FILE_W-1){1'b0}}, file_reg, 1'b0};
    assign dir_ra   = dir_base + {{(DIR_AW-DI_W){1'b0}}, di_reg};
    assign ie_ra    = {file_reg, k_reg};

    fbmap_bitmap u_bitmap (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (bm_req),
        .rsp   (bm_rsp)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (clr_cnt_reg == DIR_AW'(DIR_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_req)
                        REQ_CLEAR:   state_next = S_CLEAR;
                        REQ_MAP:
                        begin
                            if (in_lb >= LB_W'(MAP_LIMIT))
                            begin
                                state_next = S_RESULT;
                            end
                            else if (in_lb < LB_W'(DIRECT_COUNT))
                            begin
                                state_next = S_MAP_DIR_RD;
                            end
                            else
                            begin
                                state_next = S_MAP_IP_RD;
                            end
                        end
                        REQ_RELEASE: state_next = S_REL_DIR_RD;
                        default:     state_next = S_RESULT;
                    endcase
                end
            end
            S_CLEAR:
            begin
                if (di_reg == DI_W'(DIRECT_COUNT - 1))
                begin
                    state_next = S_RESULT;
                end
            end
            S_MAP_DIR_RD:  state_next = S_MAP_DIR_CHK;
            S_MAP_DIR_CHK: state_next = dir_rd_reg.valid ? S_RESULT : S_MAP_DATA_WAIT;
            S_MAP_IP_RD:   state_next = S_MAP_IP_CHK;
            S_MAP_IP_CHK:  state_next = ip_rd_reg.valid ? S_MAP_IE_RD : S_MAP_IP_WAIT;
            S_MAP_IP_WAIT:
            begin
                if (bm_rsp.done)
                begin
                    state_next = bm_rsp.ok ? S_MAP_WIPE : S_RESULT;
                end
            end
            S_MAP_WIPE:
            begin
                if (k_reg == IE_IDX_W'(INDIRECT_COUNT - 1))
                begin
                    state_next = S_MAP_DATA_WAIT;
                end
            end
            S_MAP_IE_RD:   state_next = S_MAP_IE_CHK;
            S_MAP_IE_CHK:  state_next = ie_rd_reg.valid ? S_RESULT : S_MAP_DATA_WAIT;
            S_MAP_DATA_WAIT:
            begin
                if (bm_rsp.done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_REL_DIR_RD:  state_next = S_REL_DIR_CHK;
            S_REL_DIR_CHK: state_next = dir_rd_reg.valid ? S_REL_DIR_WAIT : S_REL_IP_RD;
            S_REL_DIR_WAIT:
            begin
                if (bm_rsp.done)
                begin
                    state_next = (di_reg == DI_W'(DIRECT_COUNT - 1)) ? S_REL_IP_RD
                                                                      : S_REL_DIR_RD;
                end
            end
            S_REL_IP_RD:   state_next = S_REL_IP_CHK;
            S_REL_IP_CHK:  state_next = ip_rd_reg.valid ? S_REL_IE_RD : S_RESULT;
            S_REL_IE_RD:   state_next = S_REL_IE_CHK;
            S_REL_IE_CHK:  state_next = ie_rd_reg.valid ? S_REL_IE_WAIT : S_REL_IB_ISSUE;
            S_REL_IE_WAIT:
            begin
                if (bm_rsp.done)
                begin
                    state_next = (k_reg == IE_IDX_W'(INDIRECT_COUNT - 1)) ? S_REL_IB_ISSUE
                                                                          : S_REL_IE_RD;
                end
            end
            S_REL_IB_ISSUE: state_next = S_REL_IB_WAIT;
            S_REL_IB_WAIT:
            begin
                if (bm_rsp.done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:       state_next = S_IDLE;
        endcase
    end

    // Memory writes and bitmap commands.
    always_comb
    begin
        dir_we     = 1'b0;
        dir_wa     = dir_ra;
        dir_wd     = '0;
        ip_we      = 1'b0;
        ip_wa      = file_reg;
        ip_wd      = '0;
        ie_we      = 1'b0;
        ie_wa      = ie_ra;
        ie_wd      = '0;
        bm_req     = '0;
        bm_req.op  = BM_OP_ALLOC;
        case (state_reg)
            S_INIT:
            begin
                dir_we = 1'b1;
                dir_wa = clr_cnt_reg;
                ip_wa  = clr_cnt_reg[FILE_W-1:0];
                ip_we  = (clr_cnt_reg < DIR_AW'(NUM_FILES));
            end
            S_CLEAR:
            begin
                dir_we = 1'b1;
                ip_we  = (di_reg == DI_W'(DIRECT_COUNT - 1));
            end
            S_MAP_DIR_CHK:
            begin
                bm_req.valid = !dir_rd_reg.valid;
            end
            S_MAP_IP_CHK:
            begin
                bm_req.valid = !ip_rd_reg.valid;
            end
            S_MAP_IP_WAIT:
            begin
                ip_we = bm_rsp.done && bm_rsp.ok;
                ip_wd = '{valid: 1'b1, blk: bm_rsp.blk};
            end
            S_MAP_WIPE:
            begin
                ie_we        = 1'b1;
                bm_req.valid = (k_reg == IE_IDX_W'(INDIRECT_COUNT - 1));
            end
            S_MAP_IE_CHK:
            begin
                bm_req.valid = !ie_rd_reg.valid;
            end
            S_MAP_DATA_WAIT:
            begin
                dir_we = bm_rsp.done && bm_rsp.ok && !tgt_ie_reg;
                dir_wd = '{valid: 1'b1, blk: bm_rsp.blk};
                ie_we  = bm_rsp.done && bm_rsp.ok && tgt_ie_reg;
                ie_wa  = {file_reg, tgt_reg};
                ie_wd  = '{valid: 1'b1, blk: bm_rsp.blk};
            end
            S_REL_DIR_CHK:
            begin
                dir_we       = dir_rd_reg.valid;
                bm_req.valid = dir_rd_reg.valid;
                bm_req.op    = BM_OP_FREE;
                bm_req.blk   = dir_rd_reg.blk;
            end
            S_REL_IE_CHK:
            begin
                ie_we        = ie_rd_reg.valid;
                bm_req.valid = ie_rd_reg.valid;
                bm_req.op    = BM_OP_FREE;
                bm_req.blk   = ie_rd_reg.blk;
            end
            S_REL_IB_ISSUE:
            begin
                ip_we        = 1'b1;
                bm_req.valid = 1'b1;
                bm_req.op    = BM_OP_FREE;
                bm_req.blk   = ipblk_reg;
            end
            default:
            begin
                dir_we = 1'b0;
            end
        endcase
    end

    // Working registers and the output register.
    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        file_next     = file_reg;
        boff_next     = boff_reg;
        di_next       = di_reg;
        k_next        = k_reg;
        tgt_next      = tgt_reg;
        tgt_ie_next   = tgt_ie_reg;
        ipblk_next    = ipblk_reg;
        status_next   = status_reg;
        bnum_next     = bnum_reg;
        rboff_next    = rboff_reg;
        freed_next    = freed_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_status_next = m_status_reg;
        m_bnum_next   = m_bnum_reg;
        m_boff_next   = m_boff_reg;
        m_freed_next  = m_freed_reg;
        case (state_reg)
            S_INIT:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    file_next   = in_file;
                    boff_next   = in_boff;
                    di_next     = (in_req == REQ_MAP) ? in_lb[DI_W-1:0] : '0;
                    k_next      = '0;
                    tgt_next    = IE_IDX_W'(in_lb - LB_W'(DIRECT_COUNT));
                    tgt_ie_next = 1'b0;
                    status_next = ST_OK;
                    bnum_next   = '0;
                    rboff_next  = '0;
                    freed_next  = '0;
                    if (in_req == REQ_MAP && in_lb >= LB_W'(MAP_LIMIT))
                    begin
                        status_next = ST_OUT_RANGE;
                    end
                end
            end
            S_CLEAR:
            begin
                di_next = di_reg + 1'b1;
            end
            S_MAP_DIR_CHK:
            begin
                if (dir_rd_reg.valid)
                begin
                    bnum_next  = dir_rd_reg.blk;
                    rboff_next = boff_reg;
                end
            end
            S_MAP_IP_CHK:
            begin
                tgt_ie_next = 1'b1;
                k_next      = ip_rd_reg.valid ? tgt_reg : '0;
            end
            S_MAP_IP_WAIT:
            begin
                if (bm_rsp.done && !bm_rsp.ok)
                begin
                    status_next = ST_NO_SPACE;
                end
            end
            S_MAP_WIPE:
            begin
                k_next = k_reg + 1'b1;
            end
            S_MAP_IE_CHK:
            begin
                if (ie_rd_reg.valid)
                begin
                    bnum_next  = ie_rd_reg.blk;
                    rboff_next = boff_reg;
                end
            end
            S_MAP_DATA_WAIT:
            begin
                if (bm_rsp.done)
                begin
                    if (bm_rsp.ok)
                    begin
                        bnum_next  = bm_rsp.blk;
                        rboff_next = boff_reg;
                    end
                    else
                    begin
                        status_next = ST_NO_SPACE;
                    end
                end
            end
            S_REL_DIR_CHK:
            begin
                if (dir_rd_reg.valid)
                begin
                    freed_next = freed_reg + 1'b1;
                end
            end
            S_REL_DIR_WAIT:
            begin
                if (bm_rsp.done)
                begin
                    di_next = di_reg + 1'b1;
                end
            end
            S_REL_IP_CHK:
            begin
                ipblk_next = ip_rd_reg.blk;
                k_next     = '0;
            end
            S_REL_IE_CHK:
            begin
                if (ie_rd_reg.valid)
                begin
                    freed_next = freed_reg + 1'b1;
                end
            end
            S_REL_IE_WAIT:
            begin
                if (bm_rsp.done)
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_REL_IB_ISSUE:
            begin
                freed_next = freed_reg + 1'b1;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_bnum_next   = bnum_reg;
                    m_boff_next   = rboff_reg;
                    m_freed_next  = freed_reg;
                end
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        file_reg     <= file_next;
        boff_reg     <= boff_next;
        di_reg       <= di_next;
        k_reg        <= k_next;
        tgt_reg      <= tgt_next;
        tgt_ie_reg   <= tgt_ie_next;
        ipblk_reg    <= ipblk_next;
        status_reg   <= status_next;
        bnum_reg     <= bnum_next;
        rboff_reg    <= rboff_next;
        freed_reg    <= freed_next;
        m_status_reg <= m_status_next;
        m_bnum_reg   <= m_bnum_next;
        m_boff_reg   <= m_boff_next;
        m_freed_reg  <= m_freed_next;
    end

    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[dir_wa] <= dir_wd;
        end
        dir_rd_reg <= dir_mem[dir_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ip_we)
        begin
            ip_mem[ip_wa] <= ip_wd;
        end
        ip_rd_reg <= ip_mem[file_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ie_we)
        begin
            ie_mem[ie_wa] <= ie_wd;
        end
        ie_rd_reg <= ie_mem[ie_ra];
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {3'b000, m_freed_reg, m_boff_reg, m_bnum_reg};

endmodule

// ===== dv/tb_file_block_map_allocator_core.sv =====
// ----------------------------------------------------------------------------
// tb_file_block_map_allocator_core
// Self-checking bench for the file block map allocator core.
// ----------------------------------------------------------------------------
// A short directed list covers the edges of the map: the first and last
// mapped blocks, offsets past the map, clear, release and unknown requests.
// Random traffic then runs in four phases with different idling on each side.
// A shadow model of the bitmap and the pointer tables predicts every result
// word, and the result words are compared in order against those predictions.
// ----------------------------------------------------------------------------
module tb_file_block_map_allocator_core;
    import fbmap_pkg::*;

    localparam int         CYCLE_LIMIT = 10_000_000;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0]         status;
        logic [BLK_W-1:0]   data_block;
        logic [BOFF_W-1:0]  offset_in_block;
        logic [FREED_W-1:0] blocks_freed;
    } alloc_result_t;

    // Shadow allocator plus the queue of result words still to come.
    class alloc_scoreboard;
        bit            taken [NUM_BLOCKS];
        ptr_t          dir_ptr [DIR_DEPTH];
        ptr_t          ind_ptr [NUM_FILES];
        ptr_t          ind_ent [IE_DEPTH];
        alloc_result_t awaited [$];
        int            errors;
        int            no_space_seen;

        function new();
            foreach (taken[i]) taken[i] = 1'b0;
            foreach (dir_ptr[i]) dir_ptr[i] = '0;
            foreach (ind_ptr[i]) ind_ptr[i] = '0;
            foreach (ind_ent[i]) ind_ent[i] = '0;
            errors = 0;
            no_space_seen = 0;
        endfunction

        function bit file_holds_blocks(int f);
            return dir_ptr[f*DIRECT_COUNT].valid || ind_ptr[f].valid;
        endfunction

        // Lowest free block goes to an empty pointer; a full bitmap refuses.
        function bit fill_pointer(ref ptr_t p);
            if (p.valid)
                return 1'b1;
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                if (!taken[i])
                begin
                    taken[i] = 1'b1;
                    p.valid = 1'b1;
                    p.blk = i[BLK_W-1:0];
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_request(logic [1:0] req, int f, int off);
            alloc_result_t r;
            int            lb;
            int            cnt;
            bit            ok;
            ptr_t          p;
            r = '0;
            cnt = 0;
            lb = off / BLOCK_BYTES;
            if (req == REQ_CLEAR)
            begin
                // Blocks held by the file stay taken: they simply leak.
                for (int i = 0; i < DIRECT_COUNT; i++)
                    dir_ptr[f*DIRECT_COUNT+i].valid = 1'b0;
                ind_ptr[f].valid = 1'b0;
            end
            else if (req == REQ_MAP)
            begin
                if (lb >= MAP_LIMIT)
                begin
                    r.status = ST_OUT_RANGE;
                end
                else if (lb < DIRECT_COUNT)
                begin
                    p = dir_ptr[f*DIRECT_COUNT+lb];
                    ok = fill_pointer(p);
                    dir_ptr[f*DIRECT_COUNT+lb] = p;
                    if (ok)
                    begin
                        r.data_block = p.blk;
                        r.offset_in_block = BOFF_W'(off % BLOCK_BYTES);
                    end
                    else
                        r.status = ST_NO_SPACE;
                end
                else
                begin
                    ok = 1'b1;
                    if (!ind_ptr[f].valid)
                    begin
                        p = ind_ptr[f];
                        ok = fill_pointer(p);
                        ind_ptr[f] = p;
                        // A fresh indirect block starts with every entry empty.
                        if (ok)
                            for (int i = 0; i < INDIRECT_COUNT; i++)
                                ind_ent[f*INDIRECT_COUNT+i].valid = 1'b0;
                    end
                    if (ok)
                    begin
                        p = ind_ent[f*INDIRECT_COUNT+lb-DIRECT_COUNT];
                        ok = fill_pointer(p);
                        ind_ent[f*INDIRECT_COUNT+lb-DIRECT_COUNT] = p;
                        if (ok)
                        begin
                            r.data_block = p.blk;
                            r.offset_in_block = BOFF_W'(off % BLOCK_BYTES);
                        end
                    end
                    if (!ok)
                        r.status = ST_NO_SPACE;
                end
                if (r.status == ST_NO_SPACE)
                    no_space_seen++;
            end
            else if (req == REQ_RELEASE)
            begin
                // Direct pointers go up to the first empty one, then the
                // indirect entries likewise, then the indirect block itself.
                for (int i = 0; i < DIRECT_COUNT; i++)
                begin
                    if (!dir_ptr[f*DIRECT_COUNT+i].valid)
                        break;
                    taken[dir_ptr[f*DIRECT_COUNT+i].blk] = 1'b0;
                    dir_ptr[f*DIRECT_COUNT+i].valid = 1'b0;
                    cnt++;
                end
                if (ind_ptr[f].valid)
                begin
                    for (int i = 0; i < INDIRECT_COUNT; i++)
                    begin
                        if (!ind_ent[f*INDIRECT_COUNT+i].valid)
                            break;
                        taken[ind_ent[f*INDIRECT_COUNT+i].blk] = 1'b0;
                        ind_ent[f*INDIRECT_COUNT+i].valid = 1'b0;
                        cnt++;
                    end
                    taken[ind_ptr[f].blk] = 1'b0;
                    ind_ptr[f].valid = 1'b0;
                    cnt++;
                end
                r.blocks_freed = cnt[FREED_W-1:0];
            end
            awaited.push_back(r);
        endfunction

        function void check_result(alloc_result_t got);
            alloc_result_t exp_r;
            if (awaited.size() == 0)
            begin
                $error("result word with nothing awaited");
                errors++;
                return;
            end
            exp_r = awaited.pop_front();
            if (got.status !== exp_r.status)
            begin
                $error("status: expected %0d, got %0d", exp_r.status, got.status);
                errors++;
            end
            if (got.data_block !== exp_r.data_block)
            begin
                $error("data_block: expected %0d, got %0d",
                       exp_r.data_block, got.data_block);
                errors++;
            end
            if (got.offset_in_block !== exp_r.offset_in_block)
            begin
                $error("offset_in_block: expected %0d, got %0d",
                       exp_r.offset_in_block, got.offset_in_block);
                errors++;
            end
            if (got.blocks_freed !== exp_r.blocks_freed)
            begin
                $error("blocks_freed: expected %0d, got %0d",
                       exp_r.blocks_freed, got.blocks_freed);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    alloc_scoreboard sb;
    int              send_idle_pct;
    int              recv_stall_pct;
    int              cycles = 0;

    file_block_map_allocator_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The receiver decides its stall for each cycle on the falling edge.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result words are taken on the rising edge and checked in order.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result({m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[19:10],
                             m_axis_tdata[28:20]});
    end

    // Watchdog: a hung block must not keep the run alive forever.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_file_block_map_allocator_core failed");
            $finish;
        end
    end

    // Presents one request word and returns at the edge that accepts it.
    task automatic send_request(logic [1:0] req, int f, int off);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {7'd0, off[OFFSET_W-1:0], f[FILE_W-1:0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(req, f, off);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    // Random offset, mostly within the direct blocks or the indirect table.
    function automatic int pick_offset();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55)
            return $urandom_range(DIRECT_COUNT-1) * BLOCK_BYTES + $urandom_range(1023);
        else if (sel < 90)
            return $urandom_range(MAP_LIMIT-1, DIRECT_COUNT) * BLOCK_BYTES
                   + $urandom_range(1023);
        return $urandom_range(524287);
    endfunction

    // One random phase; the last one lets clears leak blocks until the
    // bitmap runs dry and no-space results turn up.
    task automatic random_phase(int n, bit exhaust);
        int          sel;
        int          f;
        logic [1:0]  req;
        for (int k = 0; k < n || (exhaust && sb.no_space_seen < 30 && k < n + 200);
             k++)
        begin
            sel = $urandom_range(99);
            f = $urandom_range(NUM_FILES-1);
            if (sel < 3)
                req = REQ_UNKNOWN;
            else if (sel < 9)
                req = REQ_CLEAR;
            else if (sel < (exhaust ? 100 : 86))
                req = REQ_MAP;
            else
                req = REQ_RELEASE;
            // Outside the last phase most clears become releases so that
            // the bitmap does not fill up with leaked blocks too early.
            if (!exhaust && req == REQ_CLEAR && sb.file_holds_blocks(f)
                && $urandom_range(9) < 8)
                req = REQ_RELEASE;
            send_request(req, f, pick_offset());
        end
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed edges of the map.
        send_request(REQ_UNKNOWN, 0, 0);
        send_request(REQ_MAP, 0, 0);
        send_request(REQ_MAP, 0, 1023);
        send_request(REQ_MAP, 0, 9*BLOCK_BYTES + 5);
        send_request(REQ_MAP, 0, DIRECT_COUNT*BLOCK_BYTES);
        send_request(REQ_MAP, 0, MAP_LIMIT*BLOCK_BYTES - 1);
        send_request(REQ_MAP, 0, MAP_LIMIT*BLOCK_BYTES);
        send_request(REQ_MAP, 63, 524287);
        send_request(REQ_MAP, 0, 11*BLOCK_BYTES + 512);
        send_request(REQ_RELEASE, 0, 0);
        send_request(REQ_RELEASE, 0, 0);
        send_request(REQ_MAP, 63, 0);
        send_request(REQ_MAP, 63, 20*BLOCK_BYTES + 1023);
        send_request(REQ_CLEAR, 63, 0);
        send_request(REQ_RELEASE, 63, 0);
        send_request(REQ_MAP, 63, 0);
        send_request(REQ_MAP, 42, 'h2AAAA);
        send_request(REQ_MAP, 21, 'h55555);
        send_request(REQ_RELEASE, 63, 0);
        send_request(REQ_CLEAR, 2, 0);
        // The sender holds off here until every awaited result is in.
        wait_drained();

        random_phase(350, 1'b0);
        wait_drained();
        send_idle_pct = 66;
        random_phase(350, 1'b0);
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 66;
        random_phase(350, 1'b0);
        wait_drained();
        send_idle_pct = 16;
        recv_stall_pct = 16;
        random_phase(350, 1'b1);

        wait_drained();
        repeat (1500) @(posedge clk);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("tb_file_block_map_allocator_core passed");
        else
            $display("tb_file_block_map_allocator_core failed");
        $finish;
    end

endmodule
